/* hw/rtl/rmt_pkg.sv */
// rmt_pkg: shared types for the running median tracker
// cell operation codes and the controller state encoding
// no dependencies
package rmt_pkg;

	// operation broadcast to every cell of a sorted chain
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_SHIFT_IN,
		OP_SHIFT_OUT
	} cell_op_t;

	// control bundle from the sequencer to one chain
	typedef struct packed {
		cell_op_t op;
	} chain_ctrl_t;

	typedef enum logic {
		S_IDLE,
		S_BAL
	} state_t;

endpackage

/* hw/rtl/rmt_cell.sv */
// rmt_cell: one slot of a sorted chain, holds a single sample
// takes its next value from itself, its neighbors or the broadcast sample
// depends on rmt_pkg
module rmt_cell #(
	parameter int SAMPLE_BITS = 16,
	parameter bit DESCENDING  = 1'b0
) (
	input  logic                          clk,
	input  rmt_pkg::cell_op_t             op,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          valid,
	input  logic signed [SAMPLE_BITS-1:0] prev_val,
	input  logic                          prev_keep,
	input  logic signed [SAMPLE_BITS-1:0] next_val,
	output logic                          keep,
	output logic signed [SAMPLE_BITS-1:0] val
);
	import rmt_pkg::*;

	logic signed [SAMPLE_BITS-1:0] val_q;
	logic signed [SAMPLE_BITS-1:0] val_d;

	// a valid entry stays put when it orders ahead of or ties with the new sample
	assign keep = valid && (DESCENDING ? (val_q >= sample) : (val_q <= sample));
	assign val  = val_q;

	always_comb begin
		unique case (op)
			OP_INSERT: begin
				if (keep)
					val_d = val_q;
				else if (prev_keep)
					val_d = sample;
				else
					val_d = prev_val;
			end
			OP_SHIFT_IN:  val_d = prev_val;
			OP_SHIFT_OUT: val_d = next_val;
			default:      val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

endmodule

/* hw/rtl/rmt_chain.sv */
// rmt_chain: row of rmt_cell slots kept in sorted order
// entry 0 is the head; depends on rmt_pkg and rmt_cell
module rmt_chain #(
	parameter int LEN         = 129,
	parameter int SAMPLE_BITS = 16,
	parameter bit DESCENDING  = 1'b0,
	parameter int LEN_W       = $clog2(LEN + 1)
) (
	input  logic                          clk,
	input  rmt_pkg::chain_ctrl_t          ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic signed [SAMPLE_BITS-1:0] front,
	input  logic [LEN_W-1:0]              len,
	output logic signed [SAMPLE_BITS-1:0] head0,
	output logic signed [SAMPLE_BITS-1:0] head1
);
	import rmt_pkg::*;

	logic signed [SAMPLE_BITS-1:0] val  [LEN];
	logic                          keep [LEN];

	for (genvar i = 0; i < LEN; i++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] prev_val;
		logic signed [SAMPLE_BITS-1:0] next_val;
		logic                          prev_keep;

		if (i == 0) begin : g_first
			assign prev_val  = front;
			assign prev_keep = 1'b1;
		end else begin : g_rest
			assign prev_val  = val[i-1];
			assign prev_keep = keep[i-1];
		end

		if (i == LEN - 1) begin : g_last
			assign next_val = val[i];
		end else begin : g_mid
			assign next_val = val[i+1];
		end

		rmt_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.DESCENDING (DESCENDING)
		) u_cell (
			.clk      (clk),
			.op       (ctrl.op),
			.sample   (sample),
			.valid    (LEN_W'(i) < len),
			.prev_val (prev_val),
			.prev_keep(prev_keep),
			.next_val (next_val),
			.keep     (keep[i]),
			.val      (val[i])
		);
	end

	assign head0 = val[0];
	assign head1 = val[1];

endmodule

/* hw/rtl/running_median_tracker.sv */
// running_median_tracker: running median over a stream of signed samples
// depends on rmt_pkg, rmt_chain and rmt_cell
//
// Usage: the input channel (in_valid/in_ready) carries a command bit and a
// sample. Command 0 inserts the sample, command 1 empties the store. Each
// input transfer yields exactly one result transfer on the output channel
// (out_valid/out_ready): twice the median, the number of held samples and
// a dropped flag, set when an insert found the store already full.
// The samples sit in two sorted rows of cells: the lower half in
// descending order and the upper half in ascending order, so the median
// is always read from the two row heads. Each item is first inserted into
// a row, then in the rebalance state a head moves across. The result is
// registered as the rebalance step finishes, and a new item is taken only
// once that step is done.
// A pending result in the output register does not block acceptance when
// out_ready is high in the same cycle; while the receiver stalls no new
// item is taken. Reset empties the store and the output register at once.
module running_median_tracker #(
	parameter int CAPACITY    = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS:0]   median_x2,
	output logic [$clog2(CAPACITY+1)-1:0] sample_count,
	output logic                          dropped
);
	import rmt_pkg::*;

	localparam int LEN   = (CAPACITY + 1) / 2 + 1;
	localparam int LEN_W = $clog2(LEN + 1);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	state_t state_q, state_d;
	logic [LEN_W-1:0] l_len_q, l_len_d;
	logic [LEN_W-1:0] u_len_q, u_len_d;
	logic             drop_q, drop_d;
	logic             out_valid_q;
	logic signed [SAMPLE_BITS:0] median_q, median_d;
	logic [CNT_W-1:0] count_q;

	chain_ctrl_t l_ctrl, u_ctrl;
	logic signed [SAMPLE_BITS-1:0] l_front, u_front;
	logic signed [SAMPLE_BITS-1:0] l_head0, l_head1, u_head0, u_head1;
	logic signed [SAMPLE_BITS-1:0] new_l0, new_u0;
	logic [CNT_W-1:0] total;
	logic             in_xfer;

	assign total    = CNT_W'(l_len_q) + CNT_W'(u_len_q);
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_xfer  = in_valid && in_ready;

	// lower half, largest first
	rmt_chain #(
		.LEN        (LEN),
		.SAMPLE_BITS(SAMPLE_BITS),
		.DESCENDING (1'b1),
		.LEN_W      (LEN_W)
	) u_low (
		.clk   (clk),
		.ctrl  (l_ctrl),
		.sample(sample),
		.front (l_front),
		.len   (l_len_q),
		.head0 (l_head0),
		.head1 (l_head1)
	);

	// upper half, smallest first
	rmt_chain #(
		.LEN        (LEN),
		.SAMPLE_BITS(SAMPLE_BITS),
		.DESCENDING (1'b0),
		.LEN_W      (LEN_W)
	) u_high (
		.clk   (clk),
		.ctrl  (u_ctrl),
		.sample(sample),
		.front (u_front),
		.len   (u_len_q),
		.head0 (u_head0),
		.head1 (u_head1)
	);

	always_comb begin
		state_d   = state_q;
		l_len_d   = l_len_q;
		u_len_d   = u_len_q;
		drop_d    = drop_q;
		l_ctrl.op = OP_HOLD;
		u_ctrl.op = OP_HOLD;
		l_front   = u_head0;
		u_front   = l_head0;
		new_l0    = l_head0;
		new_u0    = u_head0;
		median_d  = median_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					state_d = S_BAL;
					drop_d  = 1'b0;
					if (command) begin
						l_len_d = '0;
						u_len_d = '0;
					end else if (total >= CNT_W'(CAPACITY)) begin
						drop_d = 1'b1;
					end else if ((l_len_q == '0) || (sample <= l_head0)) begin
						l_ctrl.op = OP_INSERT;
						l_len_d   = l_len_q + LEN_W'(1);
					end else begin
						u_ctrl.op = OP_INSERT;
						u_len_d   = u_len_q + LEN_W'(1);
					end
				end
			end
			S_BAL: begin
				state_d = S_IDLE;
				if (l_len_q > (u_len_q + LEN_W'(1))) begin
					// lower half too long: its head moves to the upper half
					l_ctrl.op = OP_SHIFT_OUT;
					u_ctrl.op = OP_SHIFT_IN;
					l_len_d   = l_len_q - LEN_W'(1);
					u_len_d   = u_len_q + LEN_W'(1);
					new_l0    = l_head1;
					new_u0    = l_head0;
				end else if (u_len_q > l_len_q) begin
					u_ctrl.op = OP_SHIFT_OUT;
					l_ctrl.op = OP_SHIFT_IN;
					u_len_d   = u_len_q - LEN_W'(1);
					l_len_d   = l_len_q + LEN_W'(1);
					new_l0    = u_head0;
					new_u0    = u_head1;
				end
				if (total == '0)
					median_d = '0;
				else if (total[0])
					median_d = {new_l0, 1'b0};
				else
					median_d = {new_l0[SAMPLE_BITS-1], new_l0}
						+ {new_u0[SAMPLE_BITS-1], new_u0};
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			l_len_q     <= '0;
			u_len_q     <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			l_len_q <= l_len_d;
			u_len_q <= u_len_d;
			drop_q  <= drop_d;
			if (state_q == S_BAL)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded as the rebalance step finishes
	always_ff @(posedge clk) begin
		if (state_q == S_BAL) begin
			median_q <= median_d;
			count_q  <= total;
		end
	end

	assign out_valid    = out_valid_q;
	assign median_x2    = median_q;
	assign sample_count = count_q;
	assign dropped      = drop_q;

`ifndef ASSERT_OFF
	a_balanced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> (l_len_q == u_len_q) || (l_len_q == u_len_q + LEN_W'(1)))
		else $error("halves out of balance while idle");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		total <= CNT_W'(CAPACITY))
		else $error("held count above capacity");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> ##1 out_valid_q)
		else $error("no result two cycles after input transfer");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && drop_q |-> count_q == CNT_W'(CAPACITY))
		else $error("drop flagged below capacity");
`endif

endmodule
